FILE: hw/rtl/slru_pkg.sv
// Shared constants, configuration and set-row types for the LRU cache core.
package slru_pkg;

   localparam int SETS      = 64;
   localparam int WAYS      = 4;
   localparam int ADDR_BITS = 48;

   // Fixed field widths of the access and result transfers
   localparam int ADDR_W = 48;
   localparam int CNT_W  = 32;

   localparam int TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int MAX_IB = $clog2(SETS + 1) - 1;    // floor(log2(SETS))
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Configuration registers
   localparam int OFF_CFG_W  = 4;
   localparam int IDX_CFG_W  = 3;
   localparam int WAYS_CFG_W = 3;
   localparam int PDATA_W    = 32;
   localparam int PADDR_W    = 4;

   localparam logic [OFF_CFG_W-1:0]  OFFSET_RST = 4'd2;
   localparam logic [IDX_CFG_W-1:0]  INDEX_RST  = 3'd0;
   localparam logic [WAYS_CFG_W-1:0] WAYS_RST   = 3'd1;

   typedef enum logic [1:0] {
      REG_OFFSET_BITS = 2'd0,
      REG_INDEX_BITS  = 2'd1,
      REG_WAYS_IN_USE = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [OFF_CFG_W-1:0]  offset_bits;
      logic [IDX_CFG_W-1:0]  index_bits;
      logic [WAYS_CFG_W-1:0] ways_in_use;
   } cfg_type;

   // One set as held in the tag RAM: a tag and an age rank per way (0 = most recent)
   typedef struct packed {
      logic [WAYS-1:0][TAG_W-1:0] tags;
      logic [WAYS-1:0][WAY_W-1:0] ranks;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic            hit;
      row_type         row;
      logic [WAYS-1:0] valid;
   } upd_type;

endpackage

FILE: hw/rtl/slru_if.sv
// Valid/ready channel interfaces for cache accesses and their results.
interface slru_req_if;
   import slru_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, output op, output addr, input ready);
   modport sink   (input valid, input op, input addr, output ready);
endinterface

interface slru_rsp_if;
   import slru_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [CNT_W-1:0] hit_count;
   logic [CNT_W-1:0] miss_count;
   logic [CNT_W-1:0] mem_read_count;
   logic [CNT_W-1:0] mem_write_count;

   modport source (output valid, output hit, output hit_count, output miss_count,
                   output mem_read_count, output mem_write_count, input ready);
   modport sink   (input valid, input hit, input hit_count, input miss_count,
                   input mem_read_count, input mem_write_count, output ready);
endinterface

FILE: hw/rtl/set_assoc_lru_cache_sim_core.sv
// Top level of the tag-only set-associative LRU cache core.
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    op, addr
//   rsp_bus   out   valid/ready    hit, hit_count, miss_count,
//                                  mem_read_count, mem_write_count
//   apb       in    psel/penable   paddr, pwdata, prdata, pready
//
// One access per cycle sustained while results are taken; a result is presented after its
// transfer in: the set row is read from the tag RAM at the transfer edge, and the lookup and
// update run in the lookup stage that registers the result. Back-to-back accesses to one set
// use the row just written. Reset clears valid bits, counters and control; no clearing pass.
// A stalled result holds and back-pressures the access channel.
module set_assoc_lru_cache_sim_core (
   input  logic                          clock,
   input  logic                          reset,
   slru_req_if.sink                      req_bus,
   slru_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [slru_pkg::PADDR_W-1:0]  paddr,
   input  logic [slru_pkg::PDATA_W-1:0]  pwdata,
   output logic [slru_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);
   import slru_pkg::*;

   cfg_type               cfg;
   logic [IDX_CFG_W-1:0]  ib_eff;
   logic [TAG_W-1:0]      a;
   logic [TAG_W-1:0]      a_off;
   logic [SET_W-1:0]      set_mask;
   logic [SET_W-1:0]      req_set;
   logic [OFF_CFG_W:0]    tag_shamt;
   logic [TAG_W-1:0]      req_tag;
   logic [WAYS-1:0]       in_use;

   logic                  req_xfer;
   logic                  out_free;
   logic                  s1_fire;

   logic                  s1_v_ff, s1_v_in;
   logic                  s1_op_ff, s1_op_in;
   logic [SET_W-1:0]      s1_set_ff, s1_set_in;
   logic [TAG_W-1:0]      s1_tag_ff, s1_tag_in;

   logic                  fwd_v_ff, fwd_v_in;
   logic [SET_W-1:0]      fwd_set_ff, fwd_set_in;
   row_type               fwd_row_ff, fwd_row_in;

   logic [SETS-1:0][WAYS-1:0] valid_ff, valid_in;

   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;   // also counts memory block reads
   logic [CNT_W-1:0]      wr_cnt_ff, wr_cnt_in;
   logic                  out_v_ff, out_v_in;
   logic                  out_hit_ff, out_hit_in;

   logic [SET_W-1:0]      rd_addr;
   logic [ROW_W-1:0]      rd_data;
   row_type               row_cur;
   upd_type               upd;

   slru_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Address split
   always_comb begin
      ib_eff    = (int'(cfg.index_bits) > MAX_IB) ? IDX_CFG_W'(MAX_IB) : cfg.index_bits;
      a         = req_bus.addr[TAG_W-1:0];
      a_off     = a >> cfg.offset_bits;
      set_mask  = ~({SET_W{1'b1}} << ib_eff);
      req_set   = a_off[SET_W-1:0] & set_mask;
      tag_shamt = {1'b0, cfg.offset_bits} + (OFF_CFG_W + 1)'(ib_eff);
      req_tag   = a >> tag_shamt;
      for (int w = 0; w < WAYS; w++) begin
         in_use[w] = (w == 0) || (w < int'(cfg.ways_in_use));
      end
   end

   assign out_free      = !out_v_ff || rsp_bus.ready;
   assign s1_fire       = s1_v_ff && out_free;
   assign req_bus.ready = !s1_v_ff || s1_fire;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // While the lookup stage holds, keep re-reading its own set so the row stays fresh
   assign rd_addr = req_xfer ? req_set : s1_set_ff;

   slru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_set_ff),
      .wr_data (upd.row),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The RAM read may have raced the previous update of the same set
   assign row_cur = (fwd_v_ff && fwd_set_ff == s1_set_ff) ? fwd_row_ff : row_type'(rd_data);

   slru_lru u_lru (
      .row    (row_cur),
      .valid  (valid_ff[s1_set_ff]),
      .in_use (in_use),
      .tag    (s1_tag_ff),
      .upd    (upd)
   );

   always_comb begin
      s1_v_in   = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_v_ff);
      s1_op_in  = req_xfer ? req_bus.op : s1_op_ff;
      s1_set_in = req_xfer ? req_set : s1_set_ff;
      s1_tag_in = req_xfer ? req_tag : s1_tag_ff;

      fwd_v_in   = s1_fire;
      fwd_set_in = s1_set_ff;
      fwd_row_in = upd.row;

      valid_in    = valid_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      wr_cnt_in   = wr_cnt_ff;
      out_hit_in  = out_hit_ff;
      if (s1_fire) begin
         valid_in[s1_set_ff] = upd.valid;
         hit_cnt_in  = hit_cnt_ff + CNT_W'(upd.hit);
         miss_cnt_in = miss_cnt_ff + CNT_W'(!upd.hit);
         wr_cnt_in   = wr_cnt_ff + CNT_W'(s1_op_ff);
         out_hit_in  = upd.hit;
      end
      out_v_in = s1_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         fwd_v_ff    <= 1'b0;
         valid_ff    <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         wr_cnt_ff   <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         s1_v_ff     <= s1_v_in;
         fwd_v_ff    <= fwd_v_in;
         valid_ff    <= valid_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         wr_cnt_ff   <= wr_cnt_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_set_ff  <= s1_set_in;
      s1_tag_ff  <= s1_tag_in;
      fwd_set_ff <= fwd_set_in;
      fwd_row_ff <= fwd_row_in;
      out_hit_ff <= out_hit_in;
   end

   // Counters only move when a new result is loaded, so they can drive the payload
   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.hit             = out_hit_ff;
   assign rsp_bus.hit_count       = hit_cnt_ff;
   assign rsp_bus.miss_count      = miss_cnt_ff;
   assign rsp_bus.mem_read_count  = miss_cnt_ff;
   assign rsp_bus.mem_write_count = wr_cnt_ff;

endmodule

FILE: hw/rtl/slru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slru_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ADR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [ADR_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/slru_csr.sv
// APB-style configuration registers of the cache core.
module slru_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [slru_pkg::PADDR_W-1:0]   paddr,
   input  logic [slru_pkg::PDATA_W-1:0]   pwdata,
   output logic [slru_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready,
   output slru_pkg::cfg_type              cfg
);
   import slru_pkg::*;

   logic [OFF_CFG_W-1:0]  offset_ff, offset_in;
   logic [IDX_CFG_W-1:0]  index_ff, index_in;
   logic [WAYS_CFG_W-1:0] ways_ff, ways_in;
   reg_idx_type           reg_idx;
   logic                  wr_xfer;

   assign reg_idx = reg_idx_type'(paddr[PADDR_W-1:2]);
   assign wr_xfer = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      offset_in = offset_ff;
      index_in  = index_ff;
      ways_in   = ways_ff;
      if (wr_xfer) begin
         case (reg_idx)
            REG_OFFSET_BITS: offset_in = pwdata[OFF_CFG_W-1:0];
            REG_INDEX_BITS:  index_in  = pwdata[IDX_CFG_W-1:0];
            REG_WAYS_IN_USE: ways_in   = pwdata[WAYS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OFFSET_BITS: prdata = PDATA_W'(offset_ff);
         REG_INDEX_BITS:  prdata = PDATA_W'(index_ff);
         REG_WAYS_IN_USE: prdata = PDATA_W'(ways_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RST;
         index_ff  <= INDEX_RST;
         ways_ff   <= WAYS_RST;
      end else begin
         offset_ff <= offset_in;
         index_ff  <= index_in;
         ways_ff   <= ways_in;
      end
   end

   assign cfg.offset_bits = offset_ff;
   assign cfg.index_bits  = index_ff;
   assign cfg.ways_in_use = ways_ff;

endmodule

FILE: hw/rtl/slru_lru.sv
// Per-set lookup: tag compare, victim choice and LRU rank update for one access.
module slru_lru (
   input  slru_pkg::row_type              row,
   input  logic [slru_pkg::WAYS-1:0]      valid,
   input  logic [slru_pkg::WAYS-1:0]      in_use,
   input  logic [slru_pkg::TAG_W-1:0]     tag,
   output slru_pkg::upd_type              upd
);
   import slru_pkg::*;

   localparam logic [WAY_W-1:0] RANK_LAST = WAY_W'(WAYS - 1);

   logic             hit_found;
   logic [WAY_W-1:0] hit_way;
   logic             free_found;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] old_way;
   logic [WAY_W-1:0] target;
   logic [WAY_W-1:0] r;
   logic             fill_all;

   always_comb begin
      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      old_way    = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_found && in_use[w] && valid[w] && row.tags[w] == tag) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (!free_found && in_use[w] && !valid[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
      // first in-use way holding the highest rank
      for (int w = 1; w < WAYS; w++) begin
         if (in_use[w] && row.ranks[w] > row.ranks[old_way]) begin
            old_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      if (hit_found) begin
         target = hit_way;
      end else if (free_found) begin
         target = free_way;
      end else begin
         target = old_way;
      end
      // filling an empty way ages every other valid in-use way, saturating at the last rank
      fill_all = !hit_found && free_found;
      r        = row.ranks[target];

      upd.hit   = hit_found;
      upd.row   = row;
      upd.valid = valid;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == target) begin
            upd.row.ranks[w] = '0;
         end else if (in_use[w] && valid[w] && (fill_all || row.ranks[w] < r) &&
                      row.ranks[w] != RANK_LAST) begin
            upd.row.ranks[w] = row.ranks[w] + WAY_W'(1);
         end
      end
      if (!hit_found) begin
         upd.row.tags[target] = tag;
         upd.valid[target]    = 1'b1;
      end
   end

endmodule
